/* design/sst_pkg.sv */
// shared constants for the sorted set table: sizes, opcodes and status codes
package sst_pkg;

    // table size and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // fixed field widths of the ports
    localparam int OPC_W    = 2;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 3;
    localparam int OCNT_W   = 5;

    // opcodes
    localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPC_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OPC_W-1:0] OP_POP    = 2'd2;
    localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

endpackage

/* design/sorted_set_table_core.sv */
// sorted set table: ascending table of distinct signed values held in one memory
//
// The table keeps up to CAPACITY distinct signed 32-bit values in ascending
// order in a single-port-write, single-port-read memory with registered read
// data, and answers every transfer with one result (status, smallest value,
// empty flag, entry count). One operation is worked on at a time. Insert and
// remove scan the memory one entry per cycle up to the first entry not below
// the value, then shift the entries behind it one slot per cycle and reread
// slot 0 for the new head. The scan and the shift together cover the N stored
// entries; the memory read port sets the scan and shift rate.
// The result sits in an output register, so the next item is taken while a
// result still waits for m_ready.
module sorted_set_table_core
    import sst_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OPC_W-1:0]         s_opcode,
    input  logic signed [VAL_W-1:0]  s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STAT_W-1:0]        m_status,
    output logic signed [VAL_W-1:0]  m_head_value,
    output logic                     m_is_empty,
    output logic [OCNT_W-1:0]        m_entry_count
);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRCH   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_SHUP   = 4'd3;
    localparam logic [3:0] S_INS    = 4'd4;
    localparam logic [3:0] S_SHDN   = 4'd5;
    localparam logic [3:0] S_HEAD   = 4'd6;
    localparam logic [3:0] S_HD2    = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    // entry memory
    logic signed [VAL_W-1:0] mem [CAPACITY];
    logic signed [VAL_W-1:0] rd_data_reg;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [VAL_W-1:0] wr_data;

    // control and working registers
    logic [3:0]              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [OPC_W-1:0]        op_reg, op_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]        pos_reg, pos_next;
    logic                    found_reg, found_next;
    logic [STAT_W-1:0]       status_reg, status_next;
    logic signed [VAL_W-1:0] head_reg, head_next;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]       m_status_reg, m_status_next;
    logic signed [VAL_W-1:0] m_head_reg, m_head_next;
    logic                    m_empty_reg, m_empty_next;
    logic [OCNT_W-1:0]       m_count_reg, m_count_next;

    // index of the entry now in rd_data_reg, in count width
    logic [CNT_W-1:0]        cur_idx;
    logic [CNT_W-1:0]        cur_idx_inc;

    assign cur_idx     = CNT_W'(rd_idx_reg);
    assign cur_idx_inc = cur_idx + CNT_W'(1);

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_head_value  = m_head_reg;
    assign m_is_empty    = m_empty_reg;
    assign m_entry_count = m_count_reg;

    // memory: one read and one write per cycle, registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // sequencer: scan, shift and head reread
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        rd_idx_next  = rd_idx_reg;
        pos_next     = pos_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        head_next    = head_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_head_next   = m_head_reg;
        m_empty_next  = m_empty_reg;
        m_count_next  = m_count_reg;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rd_data_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next  = s_opcode;
                    val_next = s_value;
                    unique case (s_opcode) inside
                        OP_CLEAR: begin
                            cnt_next    = '0;
                            status_next = ST_OK;
                            state_next  = S_DONE;
                        end
                        OP_POP: begin
                            if (cnt_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else begin
                                pos_next   = '0;
                                found_next = 1'b1;
                                state_next = S_DECIDE;
                            end
                        end
                        OP_INSERT, OP_REMOVE: begin
                            if (cnt_reg == '0) begin
                                pos_next   = '0;
                                found_next = 1'b0;
                                state_next = S_DECIDE;
                            end else begin
                                rd_en       = 1'b1;
                                rd_addr     = '0;
                                rd_idx_next = '0;
                                state_next  = S_SRCH;
                            end
                        end
                    endcase
                end
            end

            // one entry per cycle until the first entry not below the value or the last entry
            S_SRCH: begin
                if (rd_data_reg >= val_reg) begin
                    pos_next   = cur_idx;
                    found_next = (rd_data_reg == val_reg);
                    state_next = S_DECIDE;
                end else if (cur_idx_inc == cnt_reg) begin
                    pos_next   = cnt_reg;
                    found_next = 1'b0;
                    state_next = S_DECIDE;
                end else begin
                    rd_en       = 1'b1;
                    rd_addr     = IDX_W'(cur_idx_inc);
                    rd_idx_next = IDX_W'(cur_idx_inc);
                end
            end

            S_DECIDE: begin
                case (op_reg)
                    OP_INSERT: begin
                        if (found_reg) begin
                            status_next = ST_PRESENT;
                            state_next  = S_DONE;
                        end else if (cnt_reg == CNT_W'(CAPACITY)) begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end else if (pos_reg == cnt_reg) begin
                            // append at the tail
                            wr_en       = 1'b1;
                            wr_addr     = IDX_W'(pos_reg);
                            wr_data     = val_reg;
                            cnt_next    = cnt_reg + CNT_W'(1);
                            status_next = ST_OK;
                            state_next  = S_HEAD;
                        end else begin
                            rd_en       = 1'b1;
                            rd_addr     = IDX_W'(cnt_reg - CNT_W'(1));
                            rd_idx_next = IDX_W'(cnt_reg - CNT_W'(1));
                            status_next = ST_OK;
                            state_next  = S_SHUP;
                        end
                    end
                    default: begin
                        // remove and pop
                        if (!found_reg) begin
                            status_next = ST_NOT_FOUND;
                            state_next  = S_DONE;
                        end else begin
                            status_next = ST_OK;
                            if (pos_reg + CNT_W'(1) == cnt_reg) begin
                                cnt_next   = cnt_reg - CNT_W'(1);
                                state_next = S_HEAD;
                            end else begin
                                rd_en       = 1'b1;
                                rd_addr     = IDX_W'(pos_reg + CNT_W'(1));
                                rd_idx_next = IDX_W'(pos_reg + CNT_W'(1));
                                state_next  = S_SHDN;
                            end
                        end
                    end
                endcase
            end

            // move entries up one slot, from the tail down to the insert point
            S_SHUP: begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(cur_idx_inc);
                if (cur_idx == pos_reg) begin
                    state_next = S_INS;
                end else begin
                    rd_en       = 1'b1;
                    rd_addr     = rd_idx_reg - IDX_W'(1);
                    rd_idx_next = rd_idx_reg - IDX_W'(1);
                end
            end

            S_INS: begin
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(pos_reg);
                wr_data    = val_reg;
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = S_HEAD;
            end

            // move entries down one slot over the removed one
            S_SHDN: begin
                wr_en   = 1'b1;
                wr_addr = rd_idx_reg - IDX_W'(1);
                if (cur_idx_inc == cnt_reg) begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = S_HEAD;
                end else begin
                    rd_en       = 1'b1;
                    rd_addr     = IDX_W'(cur_idx_inc);
                    rd_idx_next = IDX_W'(cur_idx_inc);
                end
            end

            // reread slot 0 for the new smallest value
            S_HEAD: begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_HD2;
            end

            S_HD2: begin
                head_next  = rd_data_reg;
                state_next = S_DONE;
            end

            // load the result once the output register is free
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_head_next   = (cnt_reg != '0) ? head_reg : '0;
                    m_empty_next  = (cnt_reg == '0);
                    m_count_next  = OCNT_W'(cnt_reg);
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        rd_idx_reg   <= rd_idx_next;
        pos_reg      <= pos_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
        head_reg     <= head_next;
        m_status_reg <= m_status_next;
        m_head_reg   <= m_head_next;
        m_empty_reg  <= m_empty_next;
        m_count_reg  <= m_count_next;
    end

    // checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write of the same slot in one cycle");

    a_full_at_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && status_reg == ST_FULL) |-> (cnt_reg == CNT_W'(CAPACITY)))
        else $error("full status with free slots");

    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != S_IDLE))
        else $error("accepted transfer not started");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result loaded outside the done state");

endmodule

/* test/testbench.sv */
// testbench for sorted_set_table_core: directed table plus random traffic checked by a predictor
`timescale 1ns / 1ps

module testbench;
    import sst_pkg::*;

    localparam int DIR_N      = 27;
    localparam int RAND_ITEMS = 2000;
    localparam int PHASE_LEN  = 150;
    localparam int DRAIN_CYC  = 60;

    // one result of the table
    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [VAL_W-1:0]  head;
        logic                     empty;
        logic [OCNT_W-1:0]        count;
    } table_result_t;

    // one row of the directed table
    typedef struct packed {
        logic [OPC_W-1:0]         opcode;
        logic signed [VAL_W-1:0]  value;
        logic                     typed;
        table_result_t            want;
    } dir_row_t;

    logic                     aclk;
    logic                     aresetn       = 1'b0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic [OPC_W-1:0]         s_opcode      = OP_CLEAR;
    logic signed [VAL_W-1:0]  s_value       = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic [STAT_W-1:0]        m_status;
    logic signed [VAL_W-1:0]  m_head_value;
    logic                     m_is_empty;
    logic [OCNT_W-1:0]        m_entry_count;

    // predictor state: mirror of the stored set
    logic signed [VAL_W-1:0]  tbl_vals [CAPACITY];
    int                       tbl_count = 0;

    table_result_t            pending_q [$];
    dir_row_t                 dir_rows [DIR_N];
    int                       err_count  = 0;
    int                       sent_count = 0;

    // no idling on either side in this stretch of items
    wire quiet_stretch = (sent_count >= 900) && (sent_count < 1300);

    sorted_set_table_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_head_value  (m_head_value),
        .m_is_empty    (m_is_empty),
        .m_entry_count (m_entry_count)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // apply one operation to the mirror and return the result it gives
    function automatic table_result_t apply_op(input logic [OPC_W-1:0] op,
                                               input logic signed [VAL_W-1:0] val);
        table_result_t res;
        int            slot;
        int            drop;
        int            pos;
        slot = -1;
        drop = -1;
        pos  = 0;
        for (int i = 0; i < tbl_count; i++)
            if (tbl_vals[i] == val) slot = i;
        case (op)
            OP_INSERT: begin
                // a stored value wins over fullness
                if (slot >= 0) begin
                    res.status = ST_PRESENT;
                end else if (tbl_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    while (pos < tbl_count && tbl_vals[pos] < val) pos++;
                    for (int i = tbl_count; i > pos; i--) tbl_vals[i] = tbl_vals[i-1];
                    tbl_vals[pos] = val;
                    tbl_count++;
                    res.status = ST_OK;
                end
            end
            OP_REMOVE: begin
                res.status = (slot >= 0) ? ST_OK : ST_NOT_FOUND;
                drop = slot;
            end
            OP_POP: begin
                res.status = (tbl_count > 0) ? ST_OK : ST_EMPTY;
                drop = (tbl_count > 0) ? 0 : -1;
            end
            OP_CLEAR: begin
                tbl_count  = 0;
                res.status = ST_OK;
            end
        endcase
        // close the gap left by a removed entry
        if (drop >= 0) begin
            for (int i = drop; i + 1 < tbl_count; i++) tbl_vals[i] = tbl_vals[i+1];
            tbl_count--;
        end
        res.head  = (tbl_count > 0) ? tbl_vals[0] : '0;
        res.empty = (tbl_count == 0);
        res.count = OCNT_W'(tbl_count);
        return res;
    endfunction

    // value near the phase base, anywhere, or at an extreme
    function automatic logic signed [VAL_W-1:0] pick_value(input logic signed [VAL_W-1:0] base);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return base + VAL_W'($urandom_range(0, 23));
        if (r < 90) return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            default: return -1;
        endcase
    endfunction

    // drive one transfer, wait for it, then record what it must return
    task automatic send_item(input logic [OPC_W-1:0] op, input logic signed [VAL_W-1:0] val,
                             input logic typed, input table_result_t want);
        table_result_t res;
        while (!quiet_stretch && $urandom_range(0, 99) < 10) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_value  <= val;
        do @(posedge aclk); while (!(s_valid && s_ready));
        res = apply_op(op, val);
        pending_q.push_back(typed ? want : res);
        sent_count++;
    endtask

    // result side: random back-pressure and field checks
    always @(posedge aclk) begin
        table_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet_stretch || ($urandom_range(0, 99) >= 10);
            if (m_valid && m_ready) begin
                if (pending_q.size() == 0) begin
                    report_error("result transfer with nothing expected");
                end else begin
                    want = pending_q.pop_front();
                    if (m_status !== want.status)
                        report_error($sformatf("status got %0h want %0h",
                                               m_status, want.status));
                    if (m_head_value !== want.head)
                        report_error($sformatf("head_value got %0h want %0h",
                                               m_head_value, want.head));
                    if (m_is_empty !== want.empty)
                        report_error($sformatf("is_empty got %0h want %0h",
                                               m_is_empty, want.empty));
                    if (m_entry_count !== want.count)
                        report_error($sformatf("entry_count got %0h want %0h",
                                               m_entry_count, want.count));
                end
            end
        end
    end

    // stimulus
    initial begin
        int                       r;
        int                       insert_bias;
        logic signed [VAL_W-1:0]  pool_base;
        logic [OPC_W-1:0]         op;
        logic signed [VAL_W-1:0]  val;

        insert_bias = 50;
        pool_base   = '0;

        // directed rows: empty-table cases, extremes, duplicates, fill to full, clear
        dir_rows[0]  = '{OP_POP,    32'sd0,          1'b1, '{ST_EMPTY, '0, 1'b1, 5'd0}};
        dir_rows[1]  = '{OP_REMOVE, 32'sd5,          1'b1, '{ST_NOT_FOUND, '0, 1'b1, 5'd0}};
        dir_rows[2]  = '{OP_INSERT, 32'sh7fff_ffff,  1'b1, '{ST_OK, 32'sh7fff_ffff, 1'b0, 5'd1}};
        dir_rows[3]  = '{OP_INSERT, 32'sh8000_0000,  1'b1, '{ST_OK, 32'sh8000_0000, 1'b0, 5'd2}};
        dir_rows[4]  = '{OP_INSERT, 32'sh8000_0000,  1'b1,
                         '{ST_PRESENT, 32'sh8000_0000, 1'b0, 5'd2}};
        dir_rows[5]  = '{OP_REMOVE, 32'sd7,          1'b0, '0};
        dir_rows[6]  = '{OP_REMOVE, 32'sh7fff_ffff,  1'b0, '0};
        dir_rows[7]  = '{OP_POP,    32'shffff_ffff,  1'b1, '{ST_OK, '0, 1'b1, 5'd0}};
        dir_rows[8]  = '{OP_INSERT, 32'sd100,        1'b0, '0};
        dir_rows[9]  = '{OP_INSERT, -32'sd100,       1'b0, '0};
        dir_rows[10] = '{OP_INSERT, 32'sd50,         1'b0, '0};
        dir_rows[11] = '{OP_INSERT, 32'sd0,          1'b0, '0};
        dir_rows[12] = '{OP_INSERT, -32'sd1,         1'b0, '0};
        dir_rows[13] = '{OP_INSERT, 32'sd75,         1'b0, '0};
        dir_rows[14] = '{OP_INSERT, -32'sd50,        1'b0, '0};
        dir_rows[15] = '{OP_INSERT, 32'sh7fff_ffff,  1'b0, '0};
        dir_rows[16] = '{OP_INSERT, 32'sh8000_0000,  1'b0, '0};
        dir_rows[17] = '{OP_INSERT, 32'sd25,         1'b0, '0};
        dir_rows[18] = '{OP_INSERT, -32'sd25,        1'b0, '0};
        dir_rows[19] = '{OP_INSERT, 32'sd60,         1'b0, '0};
        dir_rows[20] = '{OP_INSERT, -32'sd60,        1'b0, '0};
        dir_rows[21] = '{OP_INSERT, 32'sd10,         1'b0, '0};
        dir_rows[22] = '{OP_INSERT, -32'sd10,        1'b0, '0};
        dir_rows[23] = '{OP_INSERT, 32'sd1,          1'b0, '0};
        dir_rows[24] = '{OP_INSERT, 32'sd5,          1'b1,
                         '{ST_FULL, 32'sh8000_0000, 1'b0, 5'd16}};
        dir_rows[25] = '{OP_INSERT, -32'sd1,         1'b1,
                         '{ST_PRESENT, 32'sh8000_0000, 1'b0, 5'd16}};
        dir_rows[26] = '{OP_CLEAR,  32'sh5555_aaaa,  1'b1, '{ST_OK, '0, 1'b1, 5'd0}};

        // reset
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].opcode, dir_rows[i].value, dir_rows[i].typed,
                      dir_rows[i].want);

        // random traffic in phases: fill-heavy, balanced or draining, around a moving base
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                case ($urandom_range(0, 2))
                    0:       insert_bias = 75;
                    1:       insert_bias = 50;
                    default: insert_bias = 25;
                endcase
                case ($urandom_range(0, 3))
                    0:       pool_base = $urandom;
                    1:       pool_base = 32'sh7fff_fff4;
                    2:       pool_base = 32'sh8000_0000;
                    default: pool_base = -32'sd12;
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 2) begin
                op  = OP_CLEAR;
                val = $urandom;
            end else if (r < 2 + insert_bias) begin
                op  = OP_INSERT;
                val = pick_value(pool_base);
            end else if ($urandom_range(0, 9) < 6) begin
                op = OP_REMOVE;
                // mostly hit a stored entry
                if (tbl_count > 0 && $urandom_range(0, 99) < 70)
                    val = tbl_vals[$urandom_range(0, tbl_count - 1)];
                else
                    val = pick_value(pool_base);
            end else begin
                op  = OP_POP;
                val = $urandom;
            end
            send_item(op, val, 1'b0, '0);
        end
        s_valid <= 1'b0;

        // drain
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);

        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
